>>> hdl/ggf_pkg.sv
// shared types and constants of the grid gradient field block
`timescale 1ns / 1ps
`default_nettype none

package ggf_pkg;

  // configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // register and field widths
  localparam int GRID_WIDTH_BITS  = 11;
  localparam int GRID_HEIGHT_BITS = 16;
  localparam int INV_STEP_BITS    = 16;
  localparam int FIELD_BITS       = 24;

  // saturation limits of a field component
  localparam int FIELD_MAX = 8388607;
  localparam int FIELD_MIN = -8388608;

  // register values after reset
  localparam int RST_GRID_WIDTH  = 1024;
  localparam int RST_GRID_HEIGHT = 2;
  localparam int RST_INV_STEP    = 256;

  typedef logic [GRID_WIDTH_BITS-1:0]  ggf_gwidth_t;
  typedef logic [GRID_HEIGHT_BITS-1:0] ggf_gheight_t;
  typedef logic [INV_STEP_BITS-1:0]    ggf_inv_t;

  // register index
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1,
    CFG_INV_STEP    = 2'd2
  } ggf_cfg_e;

  // kind of y difference
  typedef enum logic [1:0] {
    YSEL_FWD,
    YSEL_CEN,
    YSEL_BWD
  } ggf_ysel_e;

  // stencil position of one result
  typedef struct packed {
    logic      first_col;
    logic      last_col;
    ggf_ysel_e ysel;
    logic      last_of_grid;
  } ggf_flags_t;

endpackage

`default_nettype wire

>>> hdl/ggf_line_mem.sv
// two-row line buffer: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module ggf_line_mem #(
  parameter int DEPTH     = 1024,
  parameter int DATA_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_BITS-1:0]     wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_BITS-1:0]     rdata_o
);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/ggf_ctrl.sv
// stream position, configuration registers, line buffer access and stencil stage
`timescale 1ns / 1ps
`default_nettype none

module ggf_ctrl #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration
  input  wire logic                                  cfg_we_i,
  input  wire logic [ggf_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire logic [ggf_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  // input channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  kind_i,
  input  wire logic signed [SAMPLE_BITS-1:0]         potential_i,
  // line buffer
  output logic                                       mem_we_o,
  output logic [$clog2(MAX_WIDTH)-1:0]               mem_waddr_o,
  output logic [2*SAMPLE_BITS-1:0]                   mem_wdata_o,
  output logic                                       mem_re_o,
  output logic [$clog2(MAX_WIDTH)-1:0]               mem_raddr_o,
  input  wire logic [2*SAMPLE_BITS-1:0]              mem_rdata_i,
  // stencil operands
  output logic                                       op_valid_o,
  input  wire logic                                  op_ready_i,
  output ggf_pkg::ggf_flags_t                        op_flags_o,
  output logic signed [SAMPLE_BITS-1:0]              op_left_o,
  output logic signed [SAMPLE_BITS-1:0]              op_center_o,
  output logic signed [SAMPLE_BITS-1:0]              op_right_o,
  output logic signed [SAMPLE_BITS-1:0]              op_up_o,
  output logic signed [SAMPLE_BITS-1:0]              op_down_o,
  output ggf_pkg::ggf_inv_t                          inv_step_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;
  localparam int HB = ggf_pkg::GRID_HEIGHT_BITS;
  localparam int SB = SAMPLE_BITS;

  ggf_pkg::ggf_gwidth_t  width_q;
  ggf_pkg::ggf_gheight_t height_q;
  ggf_pkg::ggf_inv_t     inv_q;

  logic [CW-1:0] col_q, col_d;
  logic [HB-1:0] row_q, row_d;
  logic [CW-1:0] drain_q, drain_d;
  logic          pend_q, pend_d;

  logic [2*SB-1:0] col0_q;
  logic [SB-1:0]   prev_q;

  logic                b_v_q;
  ggf_pkg::ggf_flags_t b_flags_q, b_flags_d;
  logic [SB-1:0]       b_left_q, b_center_q, b_up_q, b_down_q;

  logic [WW-1:0]   w_eff;
  logic [WW-1:0]   w_last;
  logic [HB:0]     h_eff;
  logic [HB:0]     row_inc;
  logic [CW-1:0]   pos;
  logic            at_first, at_last;
  logic [2*SB-1:0] cur;
  logic [SB-1:0]   cur_recent, cur_older;
  logic            rdy_b, accept, do_samp, do_drain, step, emit, cfg_hit;

  // effective grid size
  always_comb begin
    if (width_q < ggf_pkg::ggf_gwidth_t'(2)) begin
      w_eff = WW'(2);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_q);
    end
    if (height_q < ggf_pkg::ggf_gheight_t'(2)) begin
      h_eff = (HB+1)'(2);
    end else begin
      h_eff = {1'b0, height_q};
    end
  end

  assign w_last  = w_eff - WW'(1);
  assign row_inc = {1'b0, row_q} + (HB+1)'(1);

  assign pos      = pend_q ? drain_q : col_q;
  assign at_first = (pos == '0);
  assign at_last  = ({1'b0, pos} == w_last);

  // column 0 comes from its own register, others from the word prefetched
  // by the previous step
  assign cur        = at_first ? col0_q : mem_rdata_i;
  assign cur_recent = cur[SB-1:0];
  assign cur_older  = cur[2*SB-1:SB];

  assign rdy_b      = !b_v_q || op_ready_i;
  assign in_stall_o = !rdy_b;
  assign accept     = in_valid_i && rdy_b;
  assign do_samp    = accept && !kind_i && !pend_q;
  assign do_drain   = accept && kind_i && pend_q;
  assign step       = do_samp || do_drain;
  assign emit       = do_drain || (do_samp && (row_q != '0));
  assign cfg_hit    = cfg_we_i && (cfg_index_i inside {ggf_pkg::CFG_GRID_WIDTH,
                                                       ggf_pkg::CFG_GRID_HEIGHT,
                                                       ggf_pkg::CFG_INV_STEP});

  assign mem_we_o    = do_samp;
  assign mem_waddr_o = col_q;
  assign mem_wdata_o = {cur_recent, potential_i};
  assign mem_re_o    = step && !at_last;
  assign mem_raddr_o = pos + CW'(1);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ggf_pkg::ggf_gwidth_t'(ggf_pkg::RST_GRID_WIDTH);
      height_q <= ggf_pkg::ggf_gheight_t'(ggf_pkg::RST_GRID_HEIGHT);
      inv_q    <= ggf_pkg::ggf_inv_t'(ggf_pkg::RST_INV_STEP);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ggf_pkg::CFG_GRID_WIDTH: begin
          width_q <= cfg_data_i[ggf_pkg::GRID_WIDTH_BITS-1:0];
        end
        ggf_pkg::CFG_GRID_HEIGHT: begin
          height_q <= cfg_data_i[ggf_pkg::GRID_HEIGHT_BITS-1:0];
        end
        ggf_pkg::CFG_INV_STEP: begin
          inv_q <= cfg_data_i[ggf_pkg::INV_STEP_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // stream position
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    pend_d  = pend_q;
    if (cfg_hit) begin
      col_d   = '0;
      row_d   = '0;
      drain_d = '0;
      pend_d  = 1'b0;
    end else if (do_samp) begin
      if (at_last) begin
        col_d = '0;
        if (row_inc >= h_eff) begin
          row_d   = '0;
          drain_d = '0;
          pend_d  = 1'b1;
        end else begin
          row_d = row_inc[HB-1:0];
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end else if (do_drain) begin
      if (at_last) begin
        drain_d = '0;
        pend_d  = 1'b0;
      end else begin
        drain_d = drain_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
      pend_q  <= 1'b0;
      b_v_q   <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
      pend_q  <= pend_d;
      if (rdy_b) begin
        b_v_q <= emit;
      end
    end
  end

  always_comb begin
    b_flags_d.first_col    = at_first;
    b_flags_d.last_col     = at_last;
    b_flags_d.last_of_grid = do_drain && at_last;
    if (do_drain) begin
      b_flags_d.ysel = ggf_pkg::YSEL_BWD;
    end else if (row_q == HB'(1)) begin
      b_flags_d.ysel = ggf_pkg::YSEL_FWD;
    end else begin
      b_flags_d.ysel = ggf_pkg::YSEL_CEN;
    end
  end

  // stencil payload
  always_ff @(posedge clk_i) begin
    if (do_samp && at_first) begin
      col0_q <= {cur_recent, potential_i};
    end
    if (step) begin
      prev_q <= cur_recent;
    end
    if (rdy_b && emit) begin
      b_flags_q  <= b_flags_d;
      b_left_q   <= prev_q;
      b_center_q <= cur_recent;
      b_up_q     <= cur_older;
      b_down_q   <= potential_i;
    end
  end

  assign op_valid_o  = b_v_q;
  assign op_flags_o  = b_flags_q;
  assign op_left_o   = b_left_q;
  assign op_center_o = b_center_q;
  assign op_right_o  = mem_rdata_i[SB-1:0];
  assign op_up_o     = b_up_q;
  assign op_down_o   = b_down_q;
  assign inv_step_o  = inv_q;

endmodule

`default_nettype wire

>>> hdl/ggf_scale.sv
// difference, scaling multiply, rounding and saturation pipeline with output register
`timescale 1ns / 1ps
`default_nettype none

module ggf_scale #(
  parameter int SAMPLE_BITS     = 16,
  parameter int SCALE_FRAC_BITS = 8
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     op_valid_i,
  output logic                                          op_ready_o,
  input  wire ggf_pkg::ggf_flags_t                      op_flags_i,
  input  wire logic signed [SAMPLE_BITS-1:0]            op_left_i,
  input  wire logic signed [SAMPLE_BITS-1:0]            op_center_i,
  input  wire logic signed [SAMPLE_BITS-1:0]            op_right_i,
  input  wire logic signed [SAMPLE_BITS-1:0]            op_up_i,
  input  wire logic signed [SAMPLE_BITS-1:0]            op_down_i,
  input  wire ggf_pkg::ggf_inv_t                        inv_step_i,
  output logic                                          out_valid_o,
  input  wire logic                                     out_stall_i,
  output logic signed [ggf_pkg::FIELD_BITS-1:0]         field_x_o,
  output logic signed [ggf_pkg::FIELD_BITS-1:0]         field_y_o,
  output logic                                          last_of_grid_o,
  output logic                                          saturated_o
);

  localparam int DW     = SAMPLE_BITS + 1;
  localparam int PW     = DW + ggf_pkg::INV_STEP_BITS + 1;
  localparam int QW     = PW + 1;
  localparam int FB     = ggf_pkg::FIELD_BITS;
  localparam int HALF_N = (1 << SCALE_FRAC_BITS) / 2;
  localparam int HALF_C = 1 << SCALE_FRAC_BITS;

  logic                 c_v_q, p_v_q, o_v_q;
  logic                 rdy_c, rdy_p, rdy_o;
  logic signed [DW-1:0] ndx_d, ndy_d, ndx_q, ndy_q;
  logic                 cx_d, cy_d, c_cx_q, c_cy_q, c_last_q;
  logic signed [PW-1:0] px_q, py_q;
  logic                 p_cx_q, p_cy_q, p_last_q;
  logic [FB:0]          rx, ry;
  logic [FB-1:0]        fx_q, fy_q;
  logic                 last_q, sat_q;

  // round to nearest (ties upward), then clip; top bit flags a clip
  function automatic logic [FB:0] round_sat(input logic signed [PW-1:0] p,
                                            input logic central);
    logic signed [QW-1:0] sum;
    logic signed [QW-1:0] q;
    logic [FB:0]          r;
    if (central) begin
      sum = QW'(p) + QW'(HALF_C);
      q   = sum >>> (SCALE_FRAC_BITS + 1);
    end else begin
      sum = QW'(p) + QW'(HALF_N);
      q   = sum >>> SCALE_FRAC_BITS;
    end
    if (q > QW'(ggf_pkg::FIELD_MAX)) begin
      r = {1'b1, FB'(ggf_pkg::FIELD_MAX)};
    end else if (q < QW'(ggf_pkg::FIELD_MIN)) begin
      r = {1'b1, FB'(ggf_pkg::FIELD_MIN)};
    end else begin
      r = {1'b0, q[FB-1:0]};
    end
    return r;
  endfunction

  assign rdy_o      = !o_v_q || !out_stall_i;
  assign rdy_p      = !p_v_q || rdy_o;
  assign rdy_c      = !c_v_q || rdy_p;
  assign op_ready_o = rdy_c;

  // negated differences
  always_comb begin
    if (op_flags_i.first_col) begin
      ndx_d = DW'(op_center_i) - DW'(op_right_i);
    end else if (op_flags_i.last_col) begin
      ndx_d = DW'(op_left_i) - DW'(op_center_i);
    end else begin
      ndx_d = DW'(op_left_i) - DW'(op_right_i);
    end
    cx_d = !op_flags_i.first_col && !op_flags_i.last_col;
    case (op_flags_i.ysel)
      ggf_pkg::YSEL_FWD: ndy_d = DW'(op_center_i) - DW'(op_down_i);
      ggf_pkg::YSEL_BWD: ndy_d = DW'(op_up_i) - DW'(op_center_i);
      default:           ndy_d = DW'(op_up_i) - DW'(op_down_i);
    endcase
    cy_d = (op_flags_i.ysel == ggf_pkg::YSEL_CEN);
  end

  assign rx = round_sat(px_q, p_cx_q);
  assign ry = round_sat(py_q, p_cy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
      p_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (rdy_c) begin
        c_v_q <= op_valid_i;
      end
      if (rdy_p) begin
        p_v_q <= c_v_q;
      end
      if (rdy_o) begin
        o_v_q <= p_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && op_valid_i) begin
      ndx_q    <= ndx_d;
      ndy_q    <= ndy_d;
      c_cx_q   <= cx_d;
      c_cy_q   <= cy_d;
      c_last_q <= op_flags_i.last_of_grid;
    end
    if (rdy_p && c_v_q) begin
      px_q     <= PW'(ndx_q) * PW'($signed({1'b0, inv_step_i}));
      py_q     <= PW'(ndy_q) * PW'($signed({1'b0, inv_step_i}));
      p_cx_q   <= c_cx_q;
      p_cy_q   <= c_cy_q;
      p_last_q <= c_last_q;
    end
    if (rdy_o && p_v_q) begin
      fx_q   <= rx[FB-1:0];
      fy_q   <= ry[FB-1:0];
      last_q <= p_last_q;
      sat_q  <= rx[FB] || ry[FB];
    end
  end

  assign out_valid_o    = o_v_q;
  assign field_x_o      = fx_q;
  assign field_y_o      = fy_q;
  assign last_of_grid_o = last_q;
  assign saturated_o    = sat_q;

endmodule

`default_nettype wire

>>> hdl/grid_gradient_field.sv
// top level of the streaming grid gradient field block
// a result passes the stencil register, then the difference, product and output registers,
//   after the accept of the item that releases it (the sample one row below, or a drain tick)
// throughput: one item per cycle while in_stall_o is low; each item costs at most one write and
//   one read of the line memory
// reset: control and stream position cleared, registers to width 1024, height 2, step 1.0;
//   the line memory is not cleared, each entry is written in the first row before a result uses it
`timescale 1ns / 1ps
`default_nettype none

module grid_gradient_field #(
  parameter int MAX_WIDTH       = 1024,
  parameter int SAMPLE_BITS     = 16,
  parameter int SCALE_FRAC_BITS = 8
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  // configuration write port
  input  wire logic                                  cfg_we_i,
  input  wire logic [ggf_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire logic [ggf_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  // sample / drain tick channel
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  kind_i,
  input  wire logic signed [SAMPLE_BITS-1:0]         potential_i,
  // field result channel
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic signed [ggf_pkg::FIELD_BITS-1:0]      field_x_o,
  output logic signed [ggf_pkg::FIELD_BITS-1:0]      field_y_o,
  output logic                                       last_of_grid_o,
  output logic                                       saturated_o
);

  localparam int CW = $clog2(MAX_WIDTH);

  // line memory word: older row in the upper half, recent row in the lower half
  logic                     mem_we, mem_re;
  logic [CW-1:0]            mem_waddr, mem_raddr;
  logic [2*SAMPLE_BITS-1:0] mem_wdata, mem_rdata;

  // stencil operands between the position logic and the arithmetic
  logic                            op_valid, op_ready;
  ggf_pkg::ggf_flags_t             op_flags;
  logic signed [SAMPLE_BITS-1:0]   op_left, op_center, op_right, op_up, op_down;
  ggf_pkg::ggf_inv_t               inv_step;

  // each accepted sample writes the word of its column (older <= recent, recent <= sample)
  // and prefetches the word of the next column; the prefetched word serves the next
  // step as center and up, and this step as right. column 0 lives in a register
  // so that a row start never needs a second read
  ggf_line_mem #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (2 * SAMPLE_BITS)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // column / row / drain counters, config registers and the stencil register;
  // a write to one of the three registers restarts the stream position, memory contents stay
  ggf_ctrl #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .potential_i (potential_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .op_valid_o  (op_valid),
    .op_ready_i  (op_ready),
    .op_flags_o  (op_flags),
    .op_left_o   (op_left),
    .op_center_o (op_center),
    .op_right_o  (op_right),
    .op_up_o     (op_up),
    .op_down_o   (op_down),
    .inv_step_o  (inv_step)
  );

  // differences, multiply by the step reciprocal, round and clip; the output
  // register lets a new transfer enter while a finished result waits
  ggf_scale #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (op_valid),
    .op_ready_o     (op_ready),
    .op_flags_i     (op_flags),
    .op_left_i      (op_left),
    .op_center_i    (op_center),
    .op_right_i     (op_right),
    .op_up_i        (op_up),
    .op_down_i      (op_down),
    .inv_step_i     (inv_step),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .field_x_o      (field_x_o),
    .field_y_o      (field_y_o),
    .last_of_grid_o (last_of_grid_o),
    .saturated_o    (saturated_o)
  );

  // the prefetch never touches the column being written
  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("line memory read and write hit the same column");

  // column 0 is held in a register, never read from memory
  a_no_col0_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (mem_raddr != '0))
    else $error("line memory read of column 0");

  // input only backs up when the whole pipeline is full and the output is held
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire
